// ----- src/diff_drive_wheel_command_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the differential drive wheel command core
// Shared assertion forms, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_WHEEL_COMMAND_CORE_ASSERT_SVH
`define DIFF_DRIVE_WHEEL_COMMAND_CORE_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define DDWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define DDWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ddwc_pkg.sv -----
// ----------------------------------------------------------------------------
// ddwc_pkg
// Types, codes and fixed widths shared by the wheel command core.
// ----------------------------------------------------------------------------
package ddwc_pkg;

  // Event codes on the input beat.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_TWIST = 2'd1;
  localparam logic [1:0] FUNC_FREE  = 2'd2;

  typedef enum logic [1:0] {
    KIND_VEL     = 2'd0,
    KIND_DISABLE = 2'd1,
    KIND_ENABLE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_HALF_TREAD = 3'd0,
    REG_RPM_SCALE  = 3'd1,
    REG_INV_LEFT   = 3'd2,
    REG_INV_RIGHT  = 3'd3,
    REG_TIMEOUT    = 3'd4
  } reg_idx_t;

  localparam int HT_W      = 12;
  localparam int SCALE_W   = 24;
  localparam int TMO_W     = 16;
  localparam int TICK_W    = 16;
  localparam int SPD_W     = 16;
  localparam int RPM_W     = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [HT_W-1:0]    HT_RST    = 12'd205;
  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd8344;
  localparam logic [TMO_W-1:0]   TMO_RST   = 16'd50;

  // Speeds are carried in mm/s / 1000; the final divide is by 1000 * 2^16,
  // split as 2^(16+3) and an odd 125.
  localparam int SPEED_SCALE = 1000;
  localparam int SCALE_FRAC  = 16;
  localparam int DIV_POW2    = 3;
  localparam int DIV_ODD     = 125;

  localparam int MUL_W     = 28;                 // each product term
  localparam int V_W       = MUL_W + 1;          // signed wheel speed
  localparam int MAG_W     = MUL_W;              // |wheel speed|
  localparam int P_W       = MAG_W + SCALE_W;    // |speed| * scale
  localparam int DIV_SHIFT = SCALE_FRAC + DIV_POW2;
  localparam int N_W       = P_W - DIV_SHIFT;    // dividend for the /125 unit
  localparam int DIG_W     = 8;
  localparam int DIGITS    = (N_W + DIG_W - 1) / DIG_W;
  localparam int PAD_W     = DIGITS * DIG_W;
  localparam int REM_W     = 7;                  // remainder below 125

  localparam int QDEPTH = 2;

  localparam logic SIDE_RIGHT = 1'b0;
  localparam logic SIDE_LEFT  = 1'b1;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [SPD_W-1:0] linear_mm_s;
    logic signed [SPD_W-1:0] yaw_mrad_s;
    logic                    free_on;
  } in_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [RPM_W-1:0] right_rpm;
    logic signed [RPM_W-1:0] left_rpm;
  } out_t;

  typedef struct packed {
    logic [HT_W-1:0]    half_tread_mm;
    logic [SCALE_W-1:0] rpm_scale_q16;
    logic               left_flip;
    logic               right_flip;
    logic [TMO_W-1:0]   timeout_ticks;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_TWIST,
    OP_FREE
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [SPD_W-1:0] linear_mm_s;
    logic signed [SPD_W-1:0] yaw_mrad_s;
    logic                    free_on;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_SCALE,
    ST_DIV_GO,
    ST_DIV_WAIT
  } st_t;

  typedef struct packed {
    logic           start;
    logic [N_W-1:0] dividend;
  } div_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PAD_W-1:0] quotient;
  } div_sts_t;

endpackage

// ----- src/ddwc_div.sv -----
// ----------------------------------------------------------------------------
// ddwc_div
// Long division by the constant 125, one 8-bit digit per cycle.
// ----------------------------------------------------------------------------
module ddwc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ddwc_pkg::div_ctl_t  ctl,
  output ddwc_pkg::div_sts_t  sts
);

  localparam int CNT_W = $clog2(ddwc_pkg::DIGITS + 1);
  localparam int RW    = ddwc_pkg::REM_W;
  localparam int PW    = ddwc_pkg::PAD_W;
  localparam int DW    = ddwc_pkg::DIG_W;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]    sh_r;
  logic [PW-1:0]    quo_r;
  logic [RW-1:0]    rem_r;

  logic [RW:0]      t;
  logic [RW-1:0]    r;
  logic [DW-1:0]    dig;

  // Restoring division of the next digit, one bit per step.
  always_comb begin
    r   = rem_r;
    dig = '0;
    t   = '0;
    for (int i = 0; i < DW; i++) begin
      t = {r, sh_r[PW-1-i]};
      if (t >= (RW+1)'(ddwc_pkg::DIV_ODD)) begin
        r          = RW'(t - (RW+1)'(ddwc_pkg::DIV_ODD));
        dig[DW-1-i] = 1'b1;
      end else begin
        r = t[RW-1:0];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ddwc_pkg::DIGITS);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sh_r  <= PW'(ctl.dividend);
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_r << DW;
      rem_r <= r;
      quo_r <= {quo_r[PW-DW-1:0], dig};
    end
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

// ----- src/ddwc_front.sv -----
// ----------------------------------------------------------------------------
// ddwc_front
// Accepts input beats, classifies the event and queues live ones.
// ----------------------------------------------------------------------------
`include "diff_drive_wheel_command_core_assert.svh"

module ddwc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  ddwc_pkg::in_t    in_data,
  output logic             cmd_vld,
  output ddwc_pkg::cmd_t   cmd,
  input  logic             cmd_rdy
);

  localparam int DEPTH = ddwc_pkg::QDEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ddwc_pkg::cmd_t   q_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  ddwc_pkg::cmd_t   entry;
  logic             live;
  logic             wr_en;
  logic             rd_en;

  // Unused event codes are taken and dropped here.
  always_comb begin
    live                = 1'b1;
    entry.op            = ddwc_pkg::OP_TICK;
    entry.linear_mm_s   = in_data.linear_mm_s;
    entry.yaw_mrad_s    = in_data.yaw_mrad_s;
    entry.free_on       = in_data.free_on;
    unique case (in_data.func)
      ddwc_pkg::FUNC_TICK:  entry.op = ddwc_pkg::OP_TICK;
      ddwc_pkg::FUNC_TWIST: entry.op = ddwc_pkg::OP_TWIST;
      ddwc_pkg::FUNC_FREE:  entry.op = ddwc_pkg::OP_FREE;
      default:              live     = 1'b0;
    endcase
  end

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign cmd_vld = (cnt_r != '0);
  assign cmd     = q_mem[rd_ptr_r];
  assign wr_en   = push && !full && live;
  assign rd_en   = cmd_vld && cmd_rdy;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem[wr_ptr_r] <= entry;
    end
  end

  `DDWC_ASSERT_NEXT(a_q_fill, wr_en && !rd_en, cnt_r == $past(cnt_r) + 1'b1, "queue fill lost")
  `DDWC_ASSERT(a_q_bound, cnt_r <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ----- src/ddwc_back.sv -----
// ----------------------------------------------------------------------------
// ddwc_back
// Executes queued events: tick and free-mode bookkeeping, and the
// twist-to-rpm computation on shared mix and scale multipliers and a divider.
// ----------------------------------------------------------------------------
`include "diff_drive_wheel_command_core_assert.svh"

module ddwc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ddwc_pkg::cfg_t   cfg,
  input  logic             cmd_vld,
  input  ddwc_pkg::cmd_t   cmd,
  output logic             cmd_rdy,
  output logic             out_vld,
  output ddwc_pkg::out_t   out_data,
  input  logic             out_pop
);

  localparam int MW = ddwc_pkg::MUL_W;
  localparam int VW = ddwc_pkg::V_W;
  localparam int AW = ddwc_pkg::MAG_W;
  localparam int PW = ddwc_pkg::P_W;
  localparam int RW = ddwc_pkg::RPM_W;
  localparam int SW = ddwc_pkg::SPD_W;
  localparam int TW = ddwc_pkg::TICK_W;

  ddwc_pkg::st_t         st_r, st_nxt;
  logic                  side_r, side_nxt;
  logic signed [SW-1:0]  x_r, x_nxt;
  logic signed [SW-1:0]  yaw_r, yaw_nxt;
  logic signed [VW-1:0]  v_r, v_nxt;
  logic                  neg_r, neg_nxt;
  logic [PW-1:0]         p_r, p_nxt;
  logic signed [RW-1:0]  right_r, right_nxt;
  logic signed [RW-1:0]  left_r, left_nxt;
  logic [TW-1:0]         ticks_r, ticks_nxt;
  logic                  seen_r, seen_nxt;
  logic                  free_r, free_nxt;
  logic                  out_vld_r, out_vld_nxt;
  ddwc_pkg::out_t        out_r, out_nxt;

  ddwc_pkg::div_ctl_t    div_ctl;
  ddwc_pkg::div_sts_t    div_sts;

  logic                  slot_free;
  logic                  cmd_take;
  logic [TW-1:0]         tick_inc;
  logic                  expire;
  logic signed [MW-1:0]  yaw_e, ht_e, x_e, k_e;
  logic signed [MW-1:0]  turn, lin;
  logic signed [VW-1:0]  mix;
  logic [AW-1:0]         mag;
  logic [PW-1:0]         prod;
  logic                  inv_side;
  logic [RW-1:0]         rpm_mag;
  logic signed [RW-1:0]  rpm;

  ddwc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .sts   (div_sts)
  );

  assign slot_free = !out_vld_r || out_pop;
  assign cmd_rdy   = (st_r == ddwc_pkg::ST_IDLE) &&
                     ((cmd.op == ddwc_pkg::OP_TWIST) || slot_free);
  assign cmd_take  = cmd_vld && cmd_rdy;

  assign tick_inc = (ticks_r == '1) ? ticks_r : ticks_r + 1'b1;
  assign expire   = (cfg.timeout_ticks != '0) && seen_r && (tick_inc > cfg.timeout_ticks);

  // Wheel speed in mm/s / 1000: 1000*x +/- yaw*half_tread.
  assign yaw_e = MW'(yaw_r);
  assign ht_e  = $signed(MW'(cfg.half_tread_mm));
  assign x_e   = MW'(x_r);
  assign k_e   = MW'(ddwc_pkg::SPEED_SCALE);
  assign turn  = yaw_e * ht_e;
  assign lin   = x_e * k_e;
  assign mix   = (side_r == ddwc_pkg::SIDE_LEFT) ? (VW'(lin) - VW'(turn))
                                                 : (VW'(lin) + VW'(turn));

  assign mag      = v_r[VW-1] ? AW'(-v_r) : AW'(v_r);
  assign prod     = PW'(mag) * PW'(cfg.rpm_scale_q16);
  assign inv_side = (side_r == ddwc_pkg::SIDE_LEFT) ? cfg.left_flip : cfg.right_flip;

  // The quotient stays below 2^27, so cutting it to 32 bits loses nothing.
  assign rpm_mag = RW'(div_sts.quotient);
  assign rpm     = neg_r ? -$signed(rpm_mag) : $signed(rpm_mag);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ddwc_pkg::ST_IDLE: begin
        if (cmd_take && (cmd.op == ddwc_pkg::OP_TWIST) && !free_r) begin
          st_nxt = ddwc_pkg::ST_MIX;
        end
      end
      ddwc_pkg::ST_MIX:    st_nxt = ddwc_pkg::ST_SCALE;
      ddwc_pkg::ST_SCALE:  st_nxt = ddwc_pkg::ST_DIV_GO;
      ddwc_pkg::ST_DIV_GO: st_nxt = ddwc_pkg::ST_DIV_WAIT;
      ddwc_pkg::ST_DIV_WAIT: begin
        if (div_sts.done) begin
          st_nxt = (side_r == ddwc_pkg::SIDE_RIGHT) ? ddwc_pkg::ST_MIX : ddwc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = ddwc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    side_nxt         = side_r;
    x_nxt            = x_r;
    yaw_nxt          = yaw_r;
    v_nxt            = v_r;
    neg_nxt          = neg_r;
    p_nxt            = p_r;
    right_nxt        = right_r;
    left_nxt         = left_r;
    ticks_nxt        = ticks_r;
    seen_nxt         = seen_r;
    free_nxt         = free_r;
    out_vld_nxt      = out_vld_r && !out_pop;
    out_nxt          = out_r;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = p_r[PW-1:ddwc_pkg::DIV_SHIFT];
    unique case (st_r)
      ddwc_pkg::ST_IDLE: begin
        if (cmd_take) begin
          unique case (cmd.op)
            ddwc_pkg::OP_TICK: begin
              ticks_nxt         = tick_inc;
              out_vld_nxt       = 1'b1;
              out_nxt.kind      = ddwc_pkg::KIND_VEL;
              out_nxt.right_rpm = expire ? '0 : right_r;
              out_nxt.left_rpm  = expire ? '0 : left_r;
              if (expire) begin
                right_nxt = '0;
                left_nxt  = '0;
              end
            end
            ddwc_pkg::OP_TWIST: begin
              ticks_nxt = '0;
              seen_nxt  = 1'b1;
              x_nxt     = cmd.linear_mm_s;
              yaw_nxt   = cmd.yaw_mrad_s;
              side_nxt  = ddwc_pkg::SIDE_RIGHT;
            end
            ddwc_pkg::OP_FREE: begin
              free_nxt          = cmd.free_on;
              right_nxt         = '0;
              left_nxt          = '0;
              out_vld_nxt       = 1'b1;
              out_nxt.kind      = cmd.free_on ? ddwc_pkg::KIND_DISABLE : ddwc_pkg::KIND_ENABLE;
              out_nxt.right_rpm = '0;
              out_nxt.left_rpm  = '0;
            end
            default: ;
          endcase
        end
      end
      ddwc_pkg::ST_MIX:    v_nxt = mix;
      ddwc_pkg::ST_SCALE: begin
        p_nxt   = prod;
        neg_nxt = v_r[VW-1] ^ inv_side;
      end
      ddwc_pkg::ST_DIV_GO: div_ctl.start = 1'b1;
      ddwc_pkg::ST_DIV_WAIT: begin
        if (div_sts.done) begin
          if (side_r == ddwc_pkg::SIDE_RIGHT) begin
            right_nxt = rpm;
            side_nxt  = ddwc_pkg::SIDE_LEFT;
          end else begin
            left_nxt = rpm;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ddwc_pkg::ST_IDLE;
      side_r    <= ddwc_pkg::SIDE_RIGHT;
      right_r   <= '0;
      left_r    <= '0;
      ticks_r   <= '0;
      seen_r    <= 1'b0;
      free_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      side_r    <= side_nxt;
      right_r   <= right_nxt;
      left_r    <= left_nxt;
      ticks_r   <= ticks_nxt;
      seen_r    <= seen_nxt;
      free_r    <= free_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    yaw_r <= yaw_nxt;
    v_r   <= v_nxt;
    neg_r <= neg_nxt;
    p_r   <= p_nxt;
    out_r <= out_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_r;

  `DDWC_ASSERT(a_free_zero, free_r |-> (right_r == '0 && left_r == '0), "targets live in free mode")
  `DDWC_ASSERT(a_work_seen, (st_r != ddwc_pkg::ST_IDLE) |-> seen_r, "compute without a command")
  `DDWC_ASSERT(a_div_start, div_ctl.start |-> !div_sts.busy, "divider restarted while busy")

endmodule

// ----- src/diff_drive_wheel_command_core.sv -----
// ----------------------------------------------------------------------------
// diff_drive_wheel_command_core
// Differential drive inverse kinematics: twist commands become per-wheel
// motor rpm targets; ticks publish them under a dead-man timeout.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload      Beat accepted when
//   input     push / full        in_data      push && !full
//   result    empty / pop        out_data     pop && !empty
//   config    cfg_we             cfg_idx,     cfg_we (no wait)
//                                cfg_wdata
//
// A tick or free-mode event goes through the input queue into the result
// register once the back end is idle and that register is free. A twist
// is taken in the idle state; then per wheel the speed is formed on the mix
// multipliers, scaled on the scale multiplier and divided by 125, the back
// end waiting while the five digits are formed and the quotient is handed
// back. The two-entry input queue keeps accepting while the back end works
// or a result waits, until it is full. Reset is synchronous and active low;
// it restores the register defaults.
//
// The wheel speed is formed exactly in mm/s / 1000 units, multiplied by the
// Q16 scale, and divided by 1000 * 2^16: the power of two is a shift and the
// remaining 125 goes through the divider. The magnitude is divided, so the
// result truncates toward zero, and the sign and invert flag are applied
// afterwards. Event code 3 is taken and dropped in the front end.
// ----------------------------------------------------------------------------
module diff_drive_wheel_command_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  ddwc_pkg::in_t                      in_data,
  output logic                               empty,
  input  logic                               pop,
  output ddwc_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [ddwc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ddwc_pkg::CFG_W-1:0]         cfg_wdata
);

  ddwc_pkg::cfg_t cfg_r;
  ddwc_pkg::cmd_t cmd;
  logic           cmd_vld;
  logic           cmd_rdy;
  logic           out_vld;

  // Register file. A write takes effect at once, so writes belong between
  // events, while nothing is in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_tread_mm <= ddwc_pkg::HT_RST;
      cfg_r.rpm_scale_q16 <= ddwc_pkg::SCALE_RST;
      cfg_r.left_flip     <= 1'b0;
      cfg_r.right_flip    <= 1'b0;
      cfg_r.timeout_ticks <= ddwc_pkg::TMO_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ddwc_pkg::REG_HALF_TREAD: cfg_r.half_tread_mm <= cfg_wdata[ddwc_pkg::HT_W-1:0];
        ddwc_pkg::REG_RPM_SCALE:  cfg_r.rpm_scale_q16 <= cfg_wdata[ddwc_pkg::SCALE_W-1:0];
        ddwc_pkg::REG_INV_LEFT:   cfg_r.left_flip     <= cfg_wdata[0];
        ddwc_pkg::REG_INV_RIGHT:  cfg_r.right_flip    <= cfg_wdata[0];
        ddwc_pkg::REG_TIMEOUT:    cfg_r.timeout_ticks <= cfg_wdata[ddwc_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: takes input beats and queues the events that do something.
  ddwc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .cmd_vld (cmd_vld),
    .cmd     (cmd),
    .cmd_rdy (cmd_rdy)
  );

  // Back end: state, arithmetic and the result register.
  ddwc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_rdy  (cmd_rdy),
    .out_vld  (out_vld),
    .out_data (out_data),
    .out_pop  (pop)
  );

  assign empty = !out_vld;

endmodule

// ----- tb/sv/ddwc_checker.sv -----
// ----------------------------------------------------------------------------
// Wheel command checker
// Watches the input, result and register ports of the wheel command core.
// It keeps its own copy of the registers and the drive state, works out the
// beat that each accepted event owes, and compares every result beat with
// the oldest one owed, field by field.
// ----------------------------------------------------------------------------
module ddwc_checker
  import ddwc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  in_t                  in_data,
  input  logic                 empty,
  input  logic                 pop,
  input  out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   beats_owed
);

  localparam longint RPM_DIVISOR = longint'(SPEED_SCALE) << SCALE_FRAC;
  localparam longint RPM_MAX     = 64'sd2147483647;
  localparam longint RPM_MIN     = -64'sd2147483648;

  cfg_t                    regs;
  logic signed [RPM_W-1:0] right_tgt;
  logic signed [RPM_W-1:0] left_tgt;
  logic [TICK_W-1:0]       idle_ticks;
  logic                    cmd_seen;
  logic                    freewheel;
  out_t                    publish_q[$];
  int                      miss_cnt = 0;

  // Wheel speed in mm/s / 1000 to motor rpm, truncated toward zero.
  function automatic logic signed [RPM_W-1:0] motor_rpm(input longint speed, input logic flip);
    longint r;
    r = (speed * longint'(regs.rpm_scale_q16)) / RPM_DIVISOR;
    if (flip) r = -r;
    if (r > RPM_MAX) r = RPM_MAX;
    if (r < RPM_MIN) r = RPM_MIN;
    return r[RPM_W-1:0];
  endfunction

  task automatic take_event(input in_t ev);
    longint lin;
    longint yaw;
    longint turn;
    out_t   b;
    b = '0;
    case (ev.func)
      FUNC_TICK: begin
        if (idle_ticks != '1) idle_ticks = idle_ticks + 1'b1;
        if (regs.timeout_ticks != 0 && cmd_seen && idle_ticks > regs.timeout_ticks) begin
          right_tgt = '0;
          left_tgt  = '0;
        end
        b.kind      = KIND_VEL;
        b.right_rpm = right_tgt;
        b.left_rpm  = left_tgt;
        publish_q.push_back(b);
      end
      FUNC_TWIST: begin
        lin        = longint'(ev.linear_mm_s);
        yaw        = longint'(ev.yaw_mrad_s);
        turn       = yaw * longint'(regs.half_tread_mm);
        idle_ticks = '0;
        cmd_seen   = 1'b1;
        if (!freewheel) begin
          right_tgt = motor_rpm(lin * SPEED_SCALE + turn, regs.right_flip);
          left_tgt  = motor_rpm(lin * SPEED_SCALE - turn, regs.left_flip);
        end
      end
      FUNC_FREE: begin
        freewheel = ev.free_on;
        right_tgt = '0;
        left_tgt  = '0;
        b.kind    = ev.free_on ? KIND_DISABLE : KIND_ENABLE;
        publish_q.push_back(b);
      end
      default: ;
    endcase
  endtask

  task automatic check_beat(input out_t got);
    out_t want;
    if (publish_q.size() == 0) begin
      $display("%0t: result beat with none owed: expected nothing, actual %h", $time, got);
      miss_cnt++;
      return;
    end
    want = publish_q.pop_front();
    if (got.kind !== want.kind) begin
      $display("%0t: kind mismatch: expected %0d, actual %0d", $time, want.kind, got.kind);
      miss_cnt++;
    end
    if (got.right_rpm !== want.right_rpm) begin
      $display("%0t: right_rpm mismatch: expected %0d, actual %0d",
               $time, want.right_rpm, got.right_rpm);
      miss_cnt++;
    end
    if (got.left_rpm !== want.left_rpm) begin
      $display("%0t: left_rpm mismatch: expected %0d, actual %0d",
               $time, want.left_rpm, got.left_rpm);
      miss_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.half_tread_mm = HT_RST;
      regs.rpm_scale_q16 = SCALE_RST;
      regs.left_flip     = 1'b0;
      regs.right_flip    = 1'b0;
      regs.timeout_ticks = TMO_RST;
      right_tgt          = '0;
      left_tgt           = '0;
      idle_ticks         = '0;
      cmd_seen           = 1'b0;
      freewheel          = 1'b0;
      publish_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_HALF_TREAD: regs.half_tread_mm = cfg_wdata[HT_W-1:0];
          REG_RPM_SCALE:  regs.rpm_scale_q16 = cfg_wdata[SCALE_W-1:0];
          REG_INV_LEFT:   regs.left_flip     = cfg_wdata[0];
          REG_INV_RIGHT:  regs.right_flip    = cfg_wdata[0];
          REG_TIMEOUT:    regs.timeout_ticks = cfg_wdata[TMO_W-1:0];
          default: ;
        endcase
      end
      // A beat popped now belongs to an earlier event, so it is checked first.
      if (pop && !empty) check_beat(out_data);
      if (push && !full) take_event(in_data);
    end
    errors     <= miss_cnt;
    beats_owed <= publish_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Wheel command core testbench
// Drives tick, twist, free-mode and spare events into the core under several
// register settings and three idling patterns, with one long result stall
// that backs the core up. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import ddwc_pkg::*;

  // Event code 3 has no meaning; the core must swallow it silently.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // A twist can still be in the back end with two more in the input queue,
  // and this many quiet cycles leave the core idle.
  localparam int DRAIN_CYCLES = 80;
  // Length of the deliberate result stall.
  localparam int HOLD_CYCLES  = 400;
  // Several times the slowest correct run.
  localparam int CYCLE_LIMIT  = 200000;
  // Random beats per register setting; six settings in all.
  localparam int BEATS_PER_SETTING = 63;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 push      = 1'b0;
  logic                 pop       = 1'b0;
  logic                 cfg_we    = 1'b0;
  in_t                  in_data   = '0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 full;
  logic                 empty;
  out_t                 out_data;
  int                   errors;
  int                   beats_owed;

  // Percent of cycles in which each side sits idle, and a request counter for
  // the long result stall. All three are written with nonblocking assignments
  // so the receiver process samples them cleanly at the clock edge.
  int send_gap_pct = 0;
  int take_gap_pct = 0;
  int hold_seq     = 0;

  diff_drive_wheel_command_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  ddwc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .beats_owed (beats_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit: if the stimulus never finishes, something hung.
  initial begin : watchdog
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result side. Each cycle pop is drawn at random against the current idle
  // rate. When the stimulus bumps hold_seq, pop stays low for HOLD_CYCLES
  // counted here, while the sender keeps offering beats.
  initial begin : result_taker
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  function automatic in_t beat_of(input logic [1:0] f, input logic [SPD_W-1:0] lin,
                                  input logic [SPD_W-1:0] yaw, input logic free_req);
    in_t b;
    b.func        = f;
    b.linear_mm_s = lin;
    b.yaw_mrad_s  = yaw;
    b.free_on     = free_req;
    return b;
  endfunction

  // Mostly ticks and twists. Each twist speed is an edge or small value a third
  // of the time, so that truncation toward zero and the extremes keep coming
  // up. Free mode is left on a bit less often than off, so twists get through.
  function automatic in_t random_beat();
    int   pick;
    in_t  b;
    b = beat_of(FUNC_TICK, SPD_W'($urandom), SPD_W'($urandom), ($urandom_range(99) < 40));
    pick = $urandom_range(99);
    if (pick < 45) begin
      b.func = FUNC_TICK;
    end else if (pick < 82) begin
      b.func = FUNC_TWIST;
      case ($urandom_range(5))
        0: b.linear_mm_s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        1: b.linear_mm_s = SPD_W'($urandom_range(40) - 20);
        default: ;
      endcase
      case ($urandom_range(5))
        0: b.yaw_mrad_s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        1: b.yaw_mrad_s = SPD_W'($urandom_range(40) - 20);
        default: ;
      endcase
    end else if (pick < 95) begin
      b.func = FUNC_FREE;
    end else begin
      b.func = FUNC_SPARE;
    end
    return b;
  endfunction

  // Offers one beat and returns at the edge that takes it. push is left high
  // so that back-to-back beats never lower and raise it in one time step.
  task automatic offer_beat(input in_t b);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Stops offering, waits for every owed result beat, then lets any twist
  // still in the back end finish before registers may change.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(input logic [HT_W-1:0] ht, input logic [SCALE_W-1:0] sc,
                              input logic inv_l, input logic inv_r,
                              input logic [TMO_W-1:0] tmo);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_HALF_TREAD;
    cfg_wdata <= CFG_W'(ht);
    @(posedge clk);
    cfg_idx   <= REG_RPM_SCALE;
    cfg_wdata <= CFG_W'(sc);
    @(posedge clk);
    cfg_idx   <= REG_INV_LEFT;
    cfg_wdata <= CFG_W'(inv_l);
    @(posedge clk);
    cfg_idx   <= REG_INV_RIGHT;
    cfg_wdata <= CFG_W'(inv_r);
    @(posedge clk);
    cfg_idx   <= REG_TIMEOUT;
    cfg_wdata <= CFG_W'(tmo);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Registers drawn with a strong lean toward their ends, zero included for
  // the tread and scale, and short timeouts so the dead-man stop fires often.
  task automatic random_setting();
    logic [HT_W-1:0]    ht;
    logic [SCALE_W-1:0] sc;
    logic [TMO_W-1:0]   tmo;
    case ($urandom_range(4))
      0: ht = '0;
      1: ht = 12'd1;
      2: ht = '1;
      default: ht = HT_W'($urandom_range(4095, 1));
    endcase
    case ($urandom_range(5))
      0: sc = '0;
      1: sc = 24'd1;
      2: sc = '1;
      3: sc = SCALE_RST;
      default: sc = SCALE_W'($urandom);
    endcase
    case ($urandom_range(5))
      0: tmo = '0;
      1: tmo = '1;
      2: tmo = TMO_W'($urandom);
      default: tmo = TMO_W'($urandom_range(8, 1));
    endcase
    load_setting(ht, sc, 1'($urandom_range(1)), 1'($urandom_range(1)), tmo);
  endtask

  task automatic random_run(input int n);
    repeat (n) offer_beat(random_beat());
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    send_gap_pct <= 26;
    take_gap_pct <= 86;

    // Directed beats under the reset settings. A tick before any command,
    // free mode blocking a twist, every corner of the two speeds, a spare
    // code with all bits set, and a tiny twist that truncates to zero.
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    offer_beat(beat_of(FUNC_FREE,  16'sh0000, 16'sh0000, 1'b1));
    offer_beat(beat_of(FUNC_TWIST, 16'sd1000, 16'sd500,  1'b0));
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    offer_beat(beat_of(FUNC_FREE,  16'shFFFF, 16'shFFFF, 1'b0));
    offer_beat(beat_of(FUNC_TWIST, 16'sh7FFF, 16'sh7FFF, 1'b0));
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    offer_beat(beat_of(FUNC_TWIST, 16'sh8000, 16'sh8000, 1'b0));
    offer_beat(beat_of(FUNC_TICK,  16'shFFFF, 16'shFFFF, 1'b1));
    offer_beat(beat_of(FUNC_TWIST, 16'sh7FFF, 16'sh8000, 1'b1));
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    offer_beat(beat_of(FUNC_TWIST, 16'sh8000, 16'sh7FFF, 1'b0));
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    offer_beat(beat_of(FUNC_SPARE, 16'shFFFF, 16'shFFFF, 1'b1));
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    offer_beat(beat_of(FUNC_TWIST, -16'sd1,   16'sd1,    1'b0));
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    drain();

    // Largest tread and scale, both sides inverted, and a one-tick timeout:
    // the first tick after the twist still publishes, the second stops.
    load_setting('1, '1, 1'b1, 1'b1, 16'd1);
    offer_beat(beat_of(FUNC_TWIST, 16'sh7FFF, 16'sh7FFF, 1'b0));
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    offer_beat(beat_of(FUNC_TWIST, 16'sh8000, 16'sh8000, 1'b0));
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    offer_beat(beat_of(FUNC_TICK,  16'sh0000, 16'sh0000, 1'b0));
    drain();

    // Smallest tread and scale with the watchdog off.
    load_setting(12'd1, 24'd1, 1'b0, 1'b1, 16'd0);
    random_run(BEATS_PER_SETTING);
    drain();
    random_setting();
    random_run(BEATS_PER_SETTING);
    drain();

    // Now the sender is the slow side.
    send_gap_pct <= 86;
    take_gap_pct <= 26;
    load_setting(12'd0, '1, 1'b1, 1'b0, '1);
    random_run(BEATS_PER_SETTING);
    drain();
    random_setting();
    random_run(BEATS_PER_SETTING);
    drain();

    // No idling on either side. The receiver first stalls for a long
    // stretch while ticks keep coming, so the core fills and raises full.
    send_gap_pct <= 0;
    take_gap_pct <= 0;
    random_setting();
    hold_seq <= hold_seq + 1;
    repeat (12) offer_beat(beat_of(FUNC_TICK, SPD_W'($urandom), SPD_W'($urandom), 1'b0));
    random_run(BEATS_PER_SETTING - 12);
    drain();
    random_setting();
    random_run(BEATS_PER_SETTING);
    drain();

    if (errors == 0 && beats_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
